@@ rtl/core/lae_pkg.sv @@
package lae_pkg;

    localparam int AMP_W   = 24;
    localparam int GAIN_W  = 17;
    localparam int VEL_W   = 7;
    localparam int PHASE_W = 3;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [AMP_W-1:0]  AMP_MAX  = 24'hFF_FFFF;
    localparam logic [AMP_W-1:0]  AMP_ONE  = 24'h80_0000;
    localparam logic [AMP_W-1:0]  AMP_HALF = 24'h40_0000;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK_STEP  = 2'd0,
        REG_DECAY_STEP   = 2'd1,
        REG_FADE_STEP    = 2'd2,
        REG_RELEASE_STEP = 2'd3
    } cfg_index_t;

    typedef enum logic [4:0] {
        PH_ATTACK  = 5'b00001,
        PH_DECAY   = 5'b00010,
        PH_FADE    = 5'b00100,
        PH_RELEASE = 5'b01000,
        PH_IDLE    = 5'b10000
    } phase_t;

    // Phase codes as seen on the result bus
    localparam logic [PHASE_W-1:0] PCODE_ATTACK  = 3'd0;
    localparam logic [PHASE_W-1:0] PCODE_DECAY   = 3'd1;
    localparam logic [PHASE_W-1:0] PCODE_FADE    = 3'd2;
    localparam logic [PHASE_W-1:0] PCODE_RELEASE = 3'd3;
    localparam logic [PHASE_W-1:0] PCODE_IDLE    = 3'd4;

    localparam logic [9:0] GAIN_DIV   = 10'd127;
    localparam logic [9:0] GAIN_BIAS  = 10'd63;
    localparam logic [9:0] GAIN_MUL   = 10'd516;

    // round(v * 65536 / 127), halves up. 65536 = 516*127 + 4, so the
    // quotient is 516*v plus floor((4*v + 63) / 127), which is 0..4.
    function automatic logic [GAIN_W-1:0] vel_to_gain(input logic [VEL_W-1:0] v);
        logic [9:0]        t;
        logic [2:0]        corr;
        logic [GAIN_W-1:0] base;
        t    = {1'b0, v, 2'b00} + GAIN_BIAS;
        corr = 3'(t >= GAIN_DIV) + 3'(t >= 10'(2 * GAIN_DIV))
             + 3'(t >= 10'(3 * GAIN_DIV)) + 3'(t >= 10'(4 * GAIN_DIV));
        base = GAIN_W'(v) * GAIN_W'(GAIN_MUL);
        return base + GAIN_W'(corr);
    endfunction

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
        logic [PHASE_W-1:0] c;
        unique case (p)
            PH_ATTACK:  c = PCODE_ATTACK;
            PH_DECAY:   c = PCODE_DECAY;
            PH_FADE:    c = PCODE_FADE;
            PH_RELEASE: c = PCODE_RELEASE;
            PH_IDLE:    c = PCODE_IDLE;
            default:    c = PCODE_ATTACK;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/linear_adsr_envelope_unit.sv @@
// Linear ADSR envelope, one item per audio sample. Each input item carries
// note_on, velocity and gate; each produces exactly one result item with the
// scaled level (unsigned Q1.23) and the phase after that sample. Throughput is
// one item per clock while the result side does not stall; an accepted item
// goes through the input register, the envelope state update and the gain
// multiply into the output register, in that order. The rate is bounded by
// the state update loop: add/compare on the amplitude feeds the next sample.
// Step registers are written through the config port and must only change
// while idle.
module linear_adsr_envelope_unit
    import lae_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [AMP_W-1:0]         cfg_data,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [0] note_on, [7:1] velocity, [8] gate, [15:9] zero
    input  logic [IN_TDATA_W-1:0]    s_tdata,

    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [23:0] level, [26:24] phase, [31:27] zero
    output logic [OUT_TDATA_W-1:0]   m_tdata
);

    logic [AMP_W-1:0] attack_step_reg, decay_step_reg, fade_step_reg, release_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_step_reg  <= '0;
            decay_step_reg   <= '0;
            fade_step_reg    <= '0;
            release_step_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_ATTACK_STEP:  attack_step_reg  <= cfg_data;
                REG_DECAY_STEP:   decay_step_reg   <= cfg_data;
                REG_FADE_STEP:    fade_step_reg    <= cfg_data;
                REG_RELEASE_STEP: release_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline handshake: input reg -> state update -> output reg
    logic in_valid_reg, mid_valid_reg, out_valid_reg;
    logic out_free, mid_free, in_free, in_adv, mid_adv;

    assign out_free = !out_valid_reg || m_tready;
    assign mid_adv  = mid_valid_reg && out_free;
    assign mid_free = !mid_valid_reg || out_free;
    assign in_adv   = in_valid_reg && mid_free;
    assign in_free  = !in_valid_reg || mid_free;
    assign s_tready = in_free;

    logic              note_on_reg, gate_reg;
    logic [GAIN_W-1:0] gain_in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_free) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && s_tvalid) begin
            note_on_reg <= s_tdata[0];
            gain_in_reg <= vel_to_gain(s_tdata[VEL_W:1]);
            gate_reg    <= s_tdata[VEL_W+1];
        end
    end

    // Envelope state; it also serves as the middle pipeline stage, since it
    // is only rewritten when that stage is free.
    phase_t            phase_reg, phase_next;
    logic [AMP_W-1:0]  amp_reg, amp_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;

    always_comb begin
        phase_t          ph;
        logic [AMP_W:0]  sum;
        logic [AMP_W-1:0] sat;
        ph         = note_on_reg ? PH_ATTACK : phase_reg;
        gain_next  = note_on_reg ? gain_in_reg : gain_reg;
        phase_next = ph;
        amp_next   = amp_reg;
        sum        = {1'b0, amp_reg} + {1'b0, attack_step_reg};
        sat        = sum[AMP_W] ? AMP_MAX : sum[AMP_W-1:0];
        unique case (ph)
            PH_ATTACK: begin
                if (!gate_reg) begin
                    phase_next = PH_RELEASE;
                end else begin
                    amp_next = sat;
                    if (sat >= AMP_ONE) phase_next = PH_DECAY;
                end
            end
            PH_DECAY: begin
                if (!gate_reg) begin
                    phase_next = PH_RELEASE;
                end else begin
                    amp_next = (decay_step_reg >= amp_reg) ? '0 : amp_reg - decay_step_reg;
                    if (amp_next <= AMP_HALF) phase_next = PH_FADE;
                end
            end
            PH_FADE: begin
                if (!gate_reg) begin
                    phase_next = PH_RELEASE;
                end else begin
                    amp_next = (fade_step_reg >= amp_reg) ? '0 : amp_reg - fade_step_reg;
                end
            end
            PH_RELEASE: begin
                if (release_step_reg > amp_reg) begin
                    amp_next   = '0;
                    phase_next = PH_IDLE;
                end else begin
                    amp_next = amp_reg - release_step_reg;
                end
            end
            PH_IDLE: ;
            default: phase_next = PH_ATTACK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            amp_reg       <= '0;
            gain_reg      <= GAIN_ONE;
        end else begin
            if (mid_free) mid_valid_reg <= in_valid_reg;
            if (in_adv) begin
                phase_reg <= phase_next;
                amp_reg   <= amp_next;
                gain_reg  <= gain_next;
            end
        end
    end

    // Gain multiply, round, saturate; zero level in the idle phase
    logic [AMP_W+GAIN_W:0]   prod_rnd;
    logic [GAIN_W-16:0]      hi_bits;
    logic [AMP_W-1:0]        level;
    logic [OUT_TDATA_W-1:0]  out_data_reg;

    assign prod_rnd = (AMP_W+GAIN_W+1)'(amp_reg) * (AMP_W+GAIN_W+1)'(gain_reg)
                    + (AMP_W+GAIN_W+1)'(32768);
    assign hi_bits  = prod_rnd[AMP_W+GAIN_W:AMP_W+16];
    always_comb begin
        if (phase_reg == PH_IDLE) begin
            level = '0;
        end else if (hi_bits != '0) begin
            level = AMP_MAX;
        end else begin
            level = prod_rnd[AMP_W+15:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_adv) begin
            out_data_reg <= {(OUT_TDATA_W-AMP_W-PHASE_W)'(0), phase_code(phase_reg), level};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/core/lae_checker.sv @@
module lae_checker
    import lae_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Idle phase always reports zero level
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[26:24] == PCODE_IDLE |-> m_tdata[23:0] == '0)
        else $error("nonzero level in idle");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Only defined phase codes and zero padding appear
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[26:24] <= PCODE_IDLE && m_tdata[31:27] == '0)
        else $error("bad phase code or padding");

endmodule

bind linear_adsr_envelope_unit lae_checker u_lae_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb_top.sv @@
module tb_top;
    import lae_pkg::*;

    typedef struct packed {
        logic [AMP_W-1:0]   level;
        logic [PHASE_W-1:0] phase;
    } sample_t;

    // one directed item; fixed rows carry a hand-written expectation
    typedef struct packed {
        logic               note_on;
        logic [VEL_W-1:0]   vel;
        logic               gate;
        logic               fixed;
        logic [AMP_W-1:0]   level;
        logic [PHASE_W-1:0] phase;
    } row_t;

    localparam int NUM_ROWS     = 26;
    localparam int NUM_SETTINGS = 9;
    localparam int ITEMS_PER    = 130;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_ATTACK_STEP;
    logic [AMP_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_tdata;

    linear_adsr_envelope_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // envelope model state and step registers
    logic [PHASE_W-1:0] env_phase = PCODE_IDLE;
    logic [AMP_W-1:0]   env_amp = '0;
    logic [GAIN_W-1:0]  env_gain = GAIN_ONE;
    logic [AMP_W-1:0]   atk_step = '0;
    logic [AMP_W-1:0]   dec_step = '0;
    logic [AMP_W-1:0]   fad_step = '0;
    logic [AMP_W-1:0]   rel_step = '0;

    sample_t sample_q[$];
    int      err_count = 0;
    int      items_sent = 0;
    bit      quiet = 1'b0;
    int      stall_left = 0;
    row_t    dir_rows [NUM_ROWS];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic sample_t envelope_tick(input logic note_on, input logic [VEL_W-1:0] vel,
                                              input logic gate);
        logic [AMP_W:0] sum;
        logic [63:0]    prod;
        sample_t        s;
        if (note_on) begin
            env_phase = PCODE_ATTACK;
            env_gain  = GAIN_W'((32'(vel) * 32'(GAIN_ONE) + 32'd63) / 32'd127);
        end
        case (env_phase)
            PCODE_ATTACK: begin
                if (!gate) begin
                    env_phase = PCODE_RELEASE;
                end else begin
                    sum     = {1'b0, env_amp} + {1'b0, atk_step};
                    env_amp = sum[AMP_W] ? AMP_MAX : sum[AMP_W-1:0];
                    if (env_amp >= AMP_ONE) env_phase = PCODE_DECAY;
                end
            end
            PCODE_DECAY: begin
                if (!gate) begin
                    env_phase = PCODE_RELEASE;
                end else begin
                    env_amp = (dec_step >= env_amp) ? '0 : env_amp - dec_step;
                    if (env_amp <= AMP_HALF) env_phase = PCODE_FADE;
                end
            end
            PCODE_FADE: begin
                if (!gate) begin
                    env_phase = PCODE_RELEASE;
                end else if (env_amp != '0) begin
                    env_amp = (fad_step >= env_amp) ? '0 : env_amp - fad_step;
                end
            end
            PCODE_RELEASE: begin
                if (rel_step > env_amp) begin
                    env_amp   = '0;
                    env_phase = PCODE_IDLE;
                end else begin
                    env_amp = env_amp - rel_step;
                end
            end
            PCODE_IDLE: ;
            default: env_phase = PCODE_ATTACK;
        endcase
        prod = 64'(env_amp) * 64'(env_gain) + 64'd32768;
        prod = prod >> 16;
        if (env_phase == PCODE_IDLE) s.level = '0;
        else s.level = (prod > 64'(AMP_MAX)) ? AMP_MAX : prod[AMP_W-1:0];
        s.phase = env_phase;
        return s;
    endfunction

    task automatic put_reg(input cfg_index_t idx, input logic [AMP_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            REG_ATTACK_STEP:  atk_step = val;
            REG_DECAY_STEP:   dec_step = val;
            REG_FADE_STEP:    fad_step = val;
            REG_RELEASE_STEP: rel_step = val;
            default: ;
        endcase
    endtask

    task automatic write_steps(input logic [AMP_W-1:0] a, input logic [AMP_W-1:0] d,
                               input logic [AMP_W-1:0] f, input logic [AMP_W-1:0] r);
        put_reg(REG_ATTACK_STEP, a);
        put_reg(REG_DECAY_STEP, d);
        put_reg(REG_FADE_STEP, f);
        put_reg(REG_RELEASE_STEP, r);
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input logic note_on, input logic [VEL_W-1:0] vel, input logic gate,
                             input bit fixed = 1'b0, input sample_t fixed_val = '0);
        sample_t s;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, gate, vel, note_on};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s = envelope_tick(note_on, vel, gate);
        sample_q.push_back(fixed ? fixed_val : s);
        items_sent++;
    endtask

    // stop sending until every pending result is out, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sample_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    function automatic logic [AMP_W-1:0] pick_step();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return '0;
        if (k == 1) return AMP_ONE;
        if (k < 4) return AMP_W'($urandom_range(0, 32'h80_0000));
        return AMP_W'(32'h80_0000 / $urandom_range(2, 40) + $urandom_range(0, 255));
    endfunction

    task automatic play_phrase();
        int k;
        int hold;
        int rel;
        k = $urandom_range(0, 9);
        if (k < 7) begin
            hold = $urandom_range(0, 80);
            rel  = $urandom_range(0, 40);
            send_item(1'b1, VEL_W'($urandom), 1'b1);
            repeat (hold) send_item(1'b0, VEL_W'($urandom), 1'b1);
            repeat (rel) send_item(1'b0, VEL_W'($urandom), 1'b0);
        end else if (k == 7) begin
            // note-on with the key already up goes straight to release
            send_item(1'b1, VEL_W'($urandom), 1'b0);
            repeat ($urandom_range(0, 30)) send_item(1'b0, VEL_W'($urandom), 1'b0);
        end else begin
            repeat ($urandom_range(1, 20))
                send_item($urandom_range(0, 3) == 0, VEL_W'($urandom), 1'($urandom));
        end
    endtask

    // result side: random stall bursts, none in the quiet tail
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sample_q.size() == 0) begin
                $error("unexpected result item %h", m_tdata);
                err_count++;
            end else begin
                want = sample_q.pop_front();
                if (m_tdata[23:0] != want.level) begin
                    $error("level: expected %h, got %h", want.level, m_tdata[23:0]);
                    err_count++;
                end
                if (m_tdata[26:24] != want.phase) begin
                    $error("phase: expected %0d, got %0d", want.phase, m_tdata[26:24]);
                    err_count++;
                end
            end
        end
    end

    initial begin
        dir_rows = '{
            '{1'b0, 7'd127, 1'b0, 1'b1, 24'h00_0000, PCODE_IDLE},   // idle after reset
            '{1'b0, 7'd127, 1'b1, 1'b1, 24'h00_0000, PCODE_IDLE},   // gate alone does nothing
            '{1'b1, 7'd127, 1'b1, 1'b1, 24'h80_0000, PCODE_DECAY},  // one-step attack
            '{1'b0, 7'd0,   1'b1, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b0, 7'd0,   1'b1, 1'b0, 24'h0, PCODE_IDLE},         // reaches half
            '{1'b0, 7'd0,   1'b1, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b0, 7'd85,  1'b0, 1'b0, 24'h0, PCODE_IDLE},         // gate drop, no step
            '{1'b0, 7'd42,  1'b0, 1'b0, 24'h0, PCODE_IDLE},         // lands on zero
            '{1'b0, 7'd0,   1'b0, 1'b1, 24'h00_0000, PCODE_IDLE},
            '{1'b1, 7'd0,   1'b1, 1'b1, 24'h00_0000, PCODE_DECAY},  // zero velocity
            '{1'b1, 7'd127, 1'b1, 1'b1, 24'hFF_FFFF, PCODE_DECAY},  // attack saturates
            '{1'b1, 7'd1,   1'b0, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b1, 7'd64,  1'b1, 1'b0, 24'h0, PCODE_IDLE},         // retrigger from release
            '{1'b0, 7'd3,   1'b1, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b0, 7'd3,   1'b1, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b0, 7'd3,   1'b1, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b0, 7'd3,   1'b1, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b0, 7'd3,   1'b1, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b0, 7'd3,   1'b1, 1'b0, 24'h0, PCODE_IDLE},         // into fade
            '{1'b0, 7'd96,  1'b1, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b0, 7'd96,  1'b1, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b0, 7'd96,  1'b1, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b0, 7'd96,  1'b1, 1'b0, 24'h0, PCODE_IDLE},         // fade clamps at zero
            '{1'b0, 7'd96,  1'b1, 1'b0, 24'h0, PCODE_IDLE},         // fade holds at zero
            '{1'b0, 7'd0,   1'b0, 1'b0, 24'h0, PCODE_IDLE},
            '{1'b0, 7'd0,   1'b0, 1'b1, 24'h00_0000, PCODE_IDLE}
        };

        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        write_steps(AMP_ONE, 24'h20_0000, 24'h10_0000, 24'h30_0000);
        foreach (dir_rows[i])
            send_item(dir_rows[i].note_on, dir_rows[i].vel, dir_rows[i].gate,
                      dir_rows[i].fixed, '{dir_rows[i].level, dir_rows[i].phase});
        drain();

        for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
            if (setting == 0) write_steps(AMP_ONE, AMP_ONE, AMP_ONE, AMP_ONE);
            else if (setting == 1) write_steps('0, '0, '0, '0);
            else write_steps(pick_step(), pick_step(), pick_step(), pick_step());
            if (setting == NUM_SETTINGS - 1) quiet = 1'b1;
            items_sent = 0;
            while (items_sent < ITEMS_PER) play_phrase();
            drain();
        end

        repeat (10) @(posedge aclk);
        if (err_count == 0 && sample_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

@@ linear_adsr_envelope_unit.f @@
rtl/core/lae_pkg.sv
rtl/core/linear_adsr_envelope_unit.sv
rtl/core/lae_checker.sv
tb/tb_top.sv
